/* rtl/mtca_pkg.sv */
// Shared types, widths and register codes for the multiview k-best cost averager.
// No dependencies; imported by every module of the block.
package mtca_pkg;

  localparam int NUM_VIEWS = 8;
  localparam int COST_BITS = 20;

  // count of lanes, 0..NUM_VIEWS
  localparam int CNT_W  = $clog2(NUM_VIEWS + 1);
  localparam int LANE_W = (NUM_VIEWS > 1) ? $clog2(NUM_VIEWS) : 1;
  localparam int SUM_W  = COST_BITS + CNT_W;

  // fixed widths of the register fields and result count
  localparam int SEL_W  = 4;
  localparam int USED_W = 4;
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  // accept edge to strobe edge
  localparam int LATENCY = 6;

  localparam logic [1:0] REG_COST_CEIL  = 2'd0;
  localparam logic [1:0] REG_K_BEST     = 2'd1;
  localparam logic [1:0] REG_VIEW_COUNT = 2'd2;

  localparam logic [COST_BITS-1:0] COST_CEIL_RST  = COST_BITS'(131072);
  localparam logic [SEL_W-1:0]     K_BEST_RST     = SEL_W'(3);
  localparam logic [SEL_W-1:0]     VIEW_COUNT_RST = SEL_W'(8);

  typedef logic [COST_BITS-1:0] cost_t;

  // what one lane hands to the merge stage
  typedef struct packed {
    logic  hit;
    cost_t cost;
  } sel_t;

endpackage

/* rtl/mtca_lane.sv */
// One selection lane: ranks its own cost against all lanes and keeps it if it is
// among the kk smallest valid costs. Depends on mtca_pkg.
module mtca_lane import mtca_pkg::*; (
  input  logic                 clk,
  input  logic [LANE_W-1:0]    lane_idx,
  input  cost_t                own_cost,
  input  logic                 own_valid,
  input  cost_t                costs [NUM_VIEWS],
  input  logic [NUM_VIEWS-1:0] valids,
  input  logic [CNT_W-1:0]     kk,
  output sel_t                 sel_r
);

  logic [CNT_W-1:0] rank;
  sel_t             sel_nxt;

  // ties broken by lane index so ranks are distinct
  always_comb begin
    rank = '0;
    for (int j = 0; j < NUM_VIEWS; j++) begin
      if (valids[j] && ((costs[j] < own_cost) ||
          ((costs[j] == own_cost) && (LANE_W'(j) < lane_idx)))) begin
        rank = rank + CNT_W'(1);
      end
    end
    sel_nxt.hit  = own_valid && (rank < kk);
    sel_nxt.cost = sel_nxt.hit ? own_cost : '0;
  end

  always_ff @(posedge clk) begin
    sel_r <= sel_nxt;
  end

endmodule

/* rtl/mtca_merge.sv */
// Merge stage: sums the selected lane costs and counts them, over two registered steps.
// Depends on mtca_pkg.
module mtca_merge import mtca_pkg::*; (
  input  logic             clk,
  input  sel_t             sels [NUM_VIEWS],
  output logic [SUM_W-1:0] sum_r,
  output logic [CNT_W-1:0] cnt_r
);

  localparam int HALF = NUM_VIEWS / 2;

  logic [SUM_W-1:0] lo_nxt, hi_nxt, lo_r, hi_r;
  logic [CNT_W-1:0] cnt_nxt, cnt_p_r;

  always_comb begin
    lo_nxt  = '0;
    hi_nxt  = '0;
    cnt_nxt = '0;
    for (int i = 0; i < NUM_VIEWS; i++) begin
      if (i < HALF) begin
        lo_nxt = lo_nxt + SUM_W'(sels[i].cost);
      end else begin
        hi_nxt = hi_nxt + SUM_W'(sels[i].cost);
      end
      cnt_nxt = cnt_nxt + CNT_W'(sels[i].hit);
    end
  end

  always_ff @(posedge clk) begin
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    cnt_p_r <= cnt_nxt;
    sum_r   <= lo_r + hi_r;
    cnt_r   <= cnt_p_r;
  end

endmodule

/* rtl/mtca_div.sv */
// Mean unit: divides the sum by the used count (1..NUM_VIEWS) through a reciprocal
// table and one multiply, then picks the cost ceiling when nothing was used. Depends on mtca_pkg.
module mtca_div import mtca_pkg::*; (
  input  logic              clk,
  input  logic [SUM_W-1:0]  sum,
  input  logic [CNT_W-1:0]  cnt,
  input  cost_t             cost_ceil,
  output cost_t             pixel_cost_r,
  output logic [USED_W-1:0] used_count_r,
  output logic              cost_valid_r
);

  // exact floor division for any sum below 2**SUM_W and divisor up to 2**CNT_W - 1
  localparam int SHIFT  = SUM_W + CNT_W;
  localparam int M_W    = SHIFT + 1;
  localparam int PROD_W = SUM_W + M_W;
  localparam int TAB_N  = 1 << CNT_W;

  logic [M_W-1:0]    recip_tab [TAB_N];
  logic [PROD_W-1:0] prod_r;
  logic [CNT_W-1:0]  cnt_r;
  cost_t             quot;

  for (genvar d = 0; d < TAB_N; d++) begin : g_recip
    localparam longint DIV = (d == 0) ? 1 : d;
    localparam longint RECIP = (d == 0) ? 0 : (((64'd1 << SHIFT) + DIV - 1) / DIV);
    assign recip_tab[d] = M_W'(RECIP);
  end

  assign quot = prod_r[SHIFT +: COST_BITS];

  always_ff @(posedge clk) begin
    prod_r       <= PROD_W'(sum) * PROD_W'(recip_tab[cnt]);
    cnt_r        <= cnt;
    pixel_cost_r <= (cnt_r != '0) ? quot : cost_ceil;
    used_count_r <= USED_W'(cnt_r);
    cost_valid_r <= (cnt_r != '0);
  end

endmodule

/* rtl/multiview_topk_cost_average.sv */
// Top level of the multiview k-best cost averager: register file, input stage,
// lanes, merge and mean unit. Depends on mtca_pkg, mtca_lane, mtca_merge, mtca_div.
//
// Use: drive the eight view costs of one pixel with start high; busy stays low,
// so a pixel is taken every cycle. Each pixel gives one word on the out_ ports,
// marked by out_valid for one cycle, after it passes the input register, lane
// rank/select, two adder steps, reciprocal multiply and output select.
// Throughput is one pixel per cycle; the pipeline depth sets the latency.
// The receiver cannot stall: every result must be taken when shown.
// Registers on the APB port: 0x0 cost ceiling, 0x4 k_best, 0x8 view_count; write
// them only while no pixel is in flight. Reset (rst_n low, synchronous) drops
// all pixels in flight and loads cost ceiling 2.0, k_best 3, view_count 8.
module multiview_topk_cost_average import mtca_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  input  logic              start,
  output logic              busy,
  input  cost_t             in_view_cost_0,
  input  cost_t             in_view_cost_1,
  input  cost_t             in_view_cost_2,
  input  cost_t             in_view_cost_3,
  input  cost_t             in_view_cost_4,
  input  cost_t             in_view_cost_5,
  input  cost_t             in_view_cost_6,
  input  cost_t             in_view_cost_7,
  output logic              out_valid,
  output cost_t             out_pixel_cost,
  output logic [USED_W-1:0] out_used_count,
  output logic              out_cost_valid
);

  cost_t                cost_ceil_r, cost_ceil_nxt;
  logic [SEL_W-1:0]     k_best_r, k_best_nxt;
  logic [SEL_W-1:0]     view_count_r, view_count_nxt;
  logic [1:0]           reg_idx;
  logic                 wr_en;

  logic [LATENCY-1:0]   vld_r, vld_nxt;
  logic                 accept;
  cost_t                in_costs [NUM_VIEWS];
  cost_t                cost_a_r [NUM_VIEWS];
  logic [NUM_VIEWS-1:0] valid_a_r, valid_a_nxt;
  logic [CNT_W-1:0]     lanes, kk;
  sel_t                 sels [NUM_VIEWS];
  logic [SUM_W-1:0]     sum;
  logic [CNT_W-1:0]     cnt;

  // ---- register file
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    cost_ceil_nxt  = cost_ceil_r;
    k_best_nxt     = k_best_r;
    view_count_nxt = view_count_r;
    if (wr_en) begin
      case (reg_idx)
        REG_COST_CEIL:  cost_ceil_nxt  = pwdata[COST_BITS-1:0];
        REG_K_BEST:     k_best_nxt     = pwdata[SEL_W-1:0];
        REG_VIEW_COUNT: view_count_nxt = pwdata[SEL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_COST_CEIL:  prdata = DATA_W'(cost_ceil_r);
      REG_K_BEST:     prdata = DATA_W'(k_best_r);
      REG_VIEW_COUNT: prdata = DATA_W'(view_count_r);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cost_ceil_r  <= COST_CEIL_RST;
      k_best_r     <= K_BEST_RST;
      view_count_r <= VIEW_COUNT_RST;
    end else begin
      cost_ceil_r  <= cost_ceil_nxt;
      k_best_r     <= k_best_nxt;
      view_count_r <= view_count_nxt;
    end
  end

  // ---- active lanes and k, clamped to the lane count
  assign lanes = (view_count_r > SEL_W'(NUM_VIEWS)) ? CNT_W'(NUM_VIEWS)
                                                     : CNT_W'(view_count_r);
  assign kk    = (CNT_W'(k_best_r) > lanes || k_best_r > SEL_W'(NUM_VIEWS)) ? lanes
                                                                            : CNT_W'(k_best_r);

  // ---- input stage
  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign in_costs[0] = in_view_cost_0;
  assign in_costs[1] = in_view_cost_1;
  assign in_costs[2] = in_view_cost_2;
  assign in_costs[3] = in_view_cost_3;
  assign in_costs[4] = in_view_cost_4;
  assign in_costs[5] = in_view_cost_5;
  assign in_costs[6] = in_view_cost_6;
  assign in_costs[7] = in_view_cost_7;

  always_comb begin
    for (int i = 0; i < NUM_VIEWS; i++) begin
      valid_a_nxt[i] = (CNT_W'(i) < lanes) && (in_costs[i] < cost_ceil_r);
    end
  end

  always_ff @(posedge clk) begin
    cost_a_r  <= in_costs;
    valid_a_r <= valid_a_nxt;
  end

  assign vld_nxt = {vld_r[LATENCY-2:0], accept};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // ---- lanes
  for (genvar g = 0; g < NUM_VIEWS; g++) begin : g_lane
    mtca_lane u_lane (
      .clk       (clk),
      .lane_idx  (LANE_W'(g)),
      .own_cost  (cost_a_r[g]),
      .own_valid (valid_a_r[g]),
      .costs     (cost_a_r),
      .valids    (valid_a_r),
      .kk        (kk),
      .sel_r     (sels[g])
    );
  end

  mtca_merge u_merge (
    .clk   (clk),
    .sels  (sels),
    .sum_r (sum),
    .cnt_r (cnt)
  );

  mtca_div u_div (
    .clk          (clk),
    .sum          (sum),
    .cnt          (cnt),
    .cost_ceil    (cost_ceil_r),
    .pixel_cost_r (out_pixel_cost),
    .used_count_r (out_used_count),
    .cost_valid_r (out_cost_valid)
  );

  assign out_valid = vld_r[LATENCY-1];

endmodule

/* rtl/mtca_checker.sv */
// Port-level checks for the multiview k-best cost averager, bound to the top level.
// Depends on mtca_pkg.
module mtca_checker import mtca_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_valid,
  input cost_t             out_pixel_cost,
  input logic [USED_W-1:0] out_used_count,
  input logic              out_cost_valid
);

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LATENCY out_valid)
    else $error("word accepted but no result after fixed latency");

  a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LATENCY))
    else $error("result without an accepted word");

  a_flag_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_cost_valid == (out_used_count != '0)))
    else $error("cost_valid disagrees with used_count");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_used_count <= USED_W'(NUM_VIEWS)))
    else $error("used_count beyond lane count");

endmodule

bind multiview_topk_cost_average mtca_checker u_mtca_checker (.*);

/* tb/multiview_topk_cost_average_tb.sv */
// Self-checking testbench for multiview_topk_cost_average: APB register setup,
// pixel driver and result monitor with an in-bench k-best mean predictor.
// Depends on mtca_pkg and the multiview_topk_cost_average RTL only.
module multiview_topk_cost_average_tb import mtca_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] REG_SPARE = 2'd3;  // unmapped slot, writes must be dropped
  localparam int WATCHDOG = 2000;
  localparam int PHASES = 10;
  localparam int PHASE_ITEMS = 93;
  localparam cost_t COST_TOP = '1;

  typedef logic [NUM_VIEWS-1:0][COST_BITS-1:0] pixel_t;

  typedef struct packed {
    cost_t             pixel_cost;
    logic [USED_W-1:0] used_count;
    logic              cost_valid;
  } pixel_result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              start = 1'b0;
  logic              busy;
  cost_t             in_view_cost_0 = '0;
  cost_t             in_view_cost_1 = '0;
  cost_t             in_view_cost_2 = '0;
  cost_t             in_view_cost_3 = '0;
  cost_t             in_view_cost_4 = '0;
  cost_t             in_view_cost_5 = '0;
  cost_t             in_view_cost_6 = '0;
  cost_t             in_view_cost_7 = '0;
  logic              out_valid;
  cost_t             out_pixel_cost;
  logic [USED_W-1:0] out_used_count;
  logic              out_cost_valid;

  multiview_topk_cost_average DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .start          (start),
    .busy           (busy),
    .in_view_cost_0 (in_view_cost_0),
    .in_view_cost_1 (in_view_cost_1),
    .in_view_cost_2 (in_view_cost_2),
    .in_view_cost_3 (in_view_cost_3),
    .in_view_cost_4 (in_view_cost_4),
    .in_view_cost_5 (in_view_cost_5),
    .in_view_cost_6 (in_view_cost_6),
    .in_view_cost_7 (in_view_cost_7),
    .out_valid      (out_valid),
    .out_pixel_cost (out_pixel_cost),
    .out_used_count (out_used_count),
    .out_cost_valid (out_cost_valid)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // shadow of the register file
  cost_t       cfg_cost_ceil = COST_CEIL_RST;
  logic [3:0]  cfg_k_best = K_BEST_RST;
  logic [3:0]  cfg_view_count = VIEW_COUNT_RST;

  pixel_t        pending_pixels[$];
  pixel_result_t expected_costs[$];
  pixel_t        drv_px;
  logic          took = 1'b0;
  bit            no_gaps = 1'b0;
  int            idle_left = 0;
  int            idle_cycles = 0;
  int            errors = 0;
  int            n_taken = 0;
  int            n_checked = 0;
  int            n_unused = 0;
  int            n_settings = 0;

  function automatic pixel_result_t kbest_mean(pixel_t px);
    cost_t         sorted[NUM_VIEWS];
    cost_t         c;
    int            lanes, kk, nv, j, used, i;
    logic [31:0]   acc;
    pixel_result_t r;
    lanes = (cfg_view_count > NUM_VIEWS) ? NUM_VIEWS : int'(cfg_view_count);
    kk = (int'(cfg_k_best) > lanes) ? lanes : int'(cfg_k_best);
    nv = 0;
    for (i = 0; i < lanes; i++) begin
      c = px[i];
      if (c < cfg_cost_ceil) begin
        j = nv;
        while (j > 0 && sorted[j-1] > c) begin
          sorted[j] = sorted[j-1];
          j--;
        end
        sorted[j] = c;
        nv++;
      end
    end
    used = (kk < nv) ? kk : nv;
    acc = '0;
    for (i = 0; i < used; i++) acc += 32'(sorted[i]);
    if (used > 0) begin
      r.pixel_cost = cost_t'(acc / 32'(used));
      r.used_count = USED_W'(used);
      r.cost_valid = 1'b1;
    end else begin
      r.pixel_cost = cfg_cost_ceil;
      r.used_count = '0;
      r.cost_valid = 1'b0;
    end
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // lanes mostly straddle the current ceiling, with ties and full-range noise
  function automatic pixel_t random_pixel();
    pixel_t px;
    int     i, r;
    for (i = 0; i < NUM_VIEWS; i++) begin
      r = $urandom_range(0, 9);
      if (r < 5) px[i] = (cfg_cost_ceil > 0) ? cost_t'($urandom_range(0, cfg_cost_ceil - 1)) : '0;
      else if (r == 5) px[i] = cfg_cost_ceil;
      else if (r == 6) px[i] = cost_t'($urandom_range(cfg_cost_ceil, COST_TOP));
      else if (r == 7) px[i] = cost_t'($urandom);
      else if (r == 8) px[i] = $urandom_range(0, 1) ? COST_TOP : '0;
      else px[i] = (i > 0) ? px[$urandom_range(0, i - 1)] : cost_t'($urandom);
    end
    return px;
  endfunction

  function automatic pixel_t uniform_pixel(cost_t v);
    pixel_t px;
    int     i;
    for (i = 0; i < NUM_VIEWS; i++) px[i] = v;
    return px;
  endfunction

  // driver: a new word goes out once the previous one was taken
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || took) begin
      if (idle_left > 0) begin
        start <= 1'b0;
        idle_left--;
      end else if (pending_pixels.size() > 0) begin
        drv_px = pending_pixels.pop_front();
        in_view_cost_0 <= drv_px[0];
        in_view_cost_1 <= drv_px[1];
        in_view_cost_2 <= drv_px[2];
        in_view_cost_3 <= drv_px[3];
        in_view_cost_4 <= drv_px[4];
        in_view_cost_5 <= drv_px[5];
        in_view_cost_6 <= drv_px[6];
        in_view_cost_7 <= drv_px[7];
        start <= 1'b1;
        idle_left = pick_gap();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor, predictor hookup and watchdog
  always @(posedge clk) begin
    pixel_result_t want, got;
    took <= rst_n && start && !busy;
    if (rst_n) begin
      if (out_valid) begin
        got = '{out_pixel_cost, out_used_count, out_cost_valid};
        if (expected_costs.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: unexpected word cost=%h used=%0d valid=%b", $realtime,
                     got.pixel_cost, got.used_count, got.cost_valid);
        end else begin
          want = expected_costs.pop_front();
          n_checked++;
          if (got !== want) begin
            errors++;
            if (errors <= 10)
              $display("%0t: mismatch cost=%h/%h used=%0d/%0d valid=%b/%b (exp/got)",
                       $realtime, want.pixel_cost, got.pixel_cost, want.used_count,
                       got.used_count, want.cost_valid, got.cost_valid);
          end
        end
      end
      if (start && !busy) begin
        want = kbest_mean(drv_px);
        if (!want.cost_valid) n_unused++;
        expected_costs.push_back(want);
        n_taken++;
      end
      if ((start && !busy) || out_valid) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG) begin
        $display("Timeout: no word moved for %0d cycles", WATCHDOG);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  task automatic cfg_write(logic [1:0] idx, logic [DATA_W-1:0] val);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_COST_CEIL:  cfg_cost_ceil = val[COST_BITS-1:0];
      REG_K_BEST:     cfg_k_best = val[3:0];
      REG_VIEW_COUNT: cfg_view_count = val[3:0];
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    n_settings++;
  endtask

  task automatic drain();
    while (pending_pixels.size() > 0 || start || expected_costs.size() > 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic set_all(cost_t m, logic [3:0] k, logic [3:0] v);
    drain();
    cfg_write(REG_COST_CEIL, DATA_W'(m));
    cfg_write(REG_K_BEST, DATA_W'(k));
    cfg_write(REG_VIEW_COUNT, DATA_W'(v));
  endtask

  initial begin
    pixel_t px;
    int     p, n, i, r;
    cost_t  m;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: ceiling 2.0, three best, all eight views
    pending_pixels.push_back(uniform_pixel('0));
    pending_pixels.push_back(uniform_pixel(COST_TOP));
    pending_pixels.push_back(uniform_pixel(COST_CEIL_RST));
    pending_pixels.push_back(uniform_pixel(cost_t'(COST_CEIL_RST - 1)));
    for (i = 0; i < NUM_VIEWS; i++) px[i] = cost_t'(1000 * (NUM_VIEWS - i) + 3);
    pending_pixels.push_back(px);
    for (i = 0; i < NUM_VIEWS; i++) px[i] = cost_t'(4097 * i + 1);
    pending_pixels.push_back(px);
    px = uniform_pixel(COST_CEIL_RST);
    px[7] = cost_t'(77);
    pending_pixels.push_back(px);
    px[2] = cost_t'(5);
    pending_pixels.push_back(px);
    for (i = 0; i < NUM_VIEWS; i++) px[i] = (i % 2) ? cost_t'(10) : cost_t'(11);
    pending_pixels.push_back(px);

    set_all(COST_TOP, 4'd8, 4'd8);
    pending_pixels.push_back(uniform_pixel(cost_t'(COST_TOP - 1)));  // widest sum
    pending_pixels.push_back(uniform_pixel(COST_TOP));
    pending_pixels.push_back(random_pixel());
    set_all(COST_CEIL_RST, 4'd3, 4'd0);                    // no view active
    pending_pixels.push_back(uniform_pixel('0));
    set_all(COST_CEIL_RST, 4'd15, 4'd12);                  // both saturate to the lanes
    pending_pixels.push_back(random_pixel());
    set_all(COST_CEIL_RST, 4'd0, 4'd8);                    // nothing averaged
    pending_pixels.push_back(uniform_pixel('0));
    set_all('0, 4'd3, 4'd8);                               // nothing can be valid
    pending_pixels.push_back(uniform_pixel('0));
    drain();
    cfg_write(REG_SPARE, 32'h0000_0001);                   // must not land anywhere
    cfg_write(REG_COST_CEIL, 32'hFFF2_0000);               // upper bits dropped
    cfg_write(REG_K_BEST, 32'hABC0_0005);
    cfg_write(REG_VIEW_COUNT, 32'h1234_5676);
    pending_pixels.push_back(random_pixel());
    pending_pixels.push_back(uniform_pixel(cost_t'(20)));

    for (p = 0; p < PHASES; p++) begin
      case (p)
        0: set_all(COST_TOP, 4'd8, 4'd8);
        1: set_all(cost_t'(1), 4'd1, 4'd1);
        2: set_all('0, 4'd15, 4'd15);
        3: set_all(COST_CEIL_RST, K_BEST_RST, VIEW_COUNT_RST);
        default: begin
          r = $urandom_range(0, 3);
          if (r == 0) m = cost_t'($urandom);
          else if (r == 1) m = cost_t'($urandom_range(1, 256));
          else if (r == 2) m = COST_TOP;
          else m = COST_CEIL_RST;
          set_all(m, 4'($urandom_range(0, 15)),
                  $urandom_range(0, 3) ? 4'($urandom_range(1, 8)) : 4'($urandom_range(0, 15)));
        end
      endcase
      no_gaps = (p == 3);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        // let the pipe run dry once per phase
        if (n == PHASE_ITEMS / 2) drain();
        pending_pixels.push_back(random_pixel());
      end
    end

    drain();
    repeat (LATENCY + 4) @(posedge clk);
    if (expected_costs.size() != 0) errors += expected_costs.size();
    $display("Sent %0d pixels under %0d register writes; %0d words checked, %0d with no cost used",
             n_taken, n_settings, n_checked, n_unused);
    $display("Mismatch count: %0d", errors);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
